// ----- src/congestion_window_rtt_estimator_core_assert.svh -----
// Assertion macros used by the checker of the congestion window core.
`ifndef CONGESTION_WINDOW_RTT_ESTIMATOR_CORE_ASSERT_SVH
`define CONGESTION_WINDOW_RTT_ESTIMATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define CWRE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define CWRE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/cwre_pkg.sv -----
`default_nettype none

package cwre_pkg;

	// Field widths
	localparam int WINDOW_W = 16;
	localparam int SEQ_W    = 32;
	localparam int TIME_W   = 32;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;

	// RTT fixed point: TIME_W integer bits, RTT_FRAC fraction bits
	localparam int RTT_FRAC = 8;
	localparam int RTT_W    = TIME_W + RTT_FRAC;
	localparam int SUM_W    = RTT_W + 3;

	localparam logic [WINDOW_W-1:0] MAX_WINDOW = 16'd65535;

	// Reset values of the configuration registers
	localparam logic [CFG_W-1:0] RST_INITIAL_SSTHRESH = 16'd16;
	localparam logic [CFG_W-1:0] RST_DEFAULT_TIMEOUT  = 16'd1000;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SSTHRESH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TIMEOUT  = 1'd1;

	// Event kinds
	localparam logic OP_SEND = 1'b0;
	localparam logic OP_ACK  = 1'b1;

	// Window action decided by the front end
	typedef enum logic [1:0] {
		ACT_HOLD,
		ACT_SHRINK,
		ACT_GROW
	} act_t;

	// Classified event handed from front end to back end
	typedef struct packed {
		act_t              act;
		logic              dup;
		logic              take;
		logic [TIME_W-1:0] sample;
	} item_t;

endpackage

`default_nettype wire

// ----- src/cwre_front.sv -----
`default_nettype none

module cwre_front
	import cwre_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              operation,
	input  wire logic              timed_out,
	input  wire logic [SEQ_W-1:0]  acked_sequence,
	input  wire logic [TIME_W-1:0] acked_send_time_ms,
	input  wire logic [TIME_W-1:0] ack_arrival_time_ms,
	output logic                   push_valid,
	input  wire logic              push_ready,
	output item_t                  push_item
);

	logic              valid_s1;
	item_t             item_s1;
	logic              last_valid_q;
	logic [SEQ_W-1:0]  last_seq_q;
	logic              accept;
	logic              is_dup;
	logic [TIME_W:0]   elapsed;
	item_t             item_d;

	assign in_ready   = !valid_s1 || push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	// Classify the incoming event
	assign is_dup  = last_valid_q && (acked_sequence == last_seq_q);
	assign elapsed = {1'b0, ack_arrival_time_ms} - {1'b0, acked_send_time_ms};

	always_comb begin
		item_d.act    = ACT_HOLD;
		item_d.dup    = 1'b0;
		item_d.take   = 1'b0;
		item_d.sample = elapsed[TIME_W-1:0];
		if (operation == OP_SEND) begin
			if (timed_out) begin
				item_d.act = ACT_SHRINK;
			end
		end else if (is_dup) begin
			item_d.act = ACT_SHRINK;
			item_d.dup = 1'b1;
		end else begin
			item_d.act  = ACT_GROW;
			item_d.take = !elapsed[TIME_W];
		end
	end

	// Hold classified transaction until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

	// Track the last ack number for duplicate detection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_valid_q <= 1'b0;
			last_seq_q   <= '0;
		end else if (accept && operation == OP_ACK) begin
			last_valid_q <= 1'b1;
			last_seq_q   <= acked_sequence;
		end
	end

endmodule

`default_nettype wire

// ----- src/cwre_queue.sv -----
`default_nettype none

module cwre_queue
	import cwre_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire item_t push_item,
	output logic       pop_valid,
	input  wire logic  pop_ready,
	output item_t      pop_item
);

	item_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Store entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/cwre_back.sv -----
`default_nettype none

module cwre_back
	import cwre_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pop_valid,
	output logic                      pop_ready,
	input  wire item_t                pop_item,
	input  wire logic                 cfg_valid,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [WINDOW_W-1:0]       window_datagrams,
	output logic [TIME_W-1:0]         retransmit_timeout_ms,
	output logic                      duplicate_seen
);

	localparam logic [SUM_W-1:0] RND = SUM_W'((64'd1 << RTT_FRAC) - 64'd1);

	logic                en;
	logic                pop;
	logic [CFG_W-1:0]    default_to_q;

	// Stage 1 state and carried fields
	logic                valid_s1;
	logic [WINDOW_W-1:0] window_q;
	logic [WINDOW_W-1:0] ssthresh_q;
	logic [WINDOW_W-1:0] ack_count_q;
	logic [RTT_W-1:0]    est_q;
	logic                rtt_valid_q;
	logic                dup_s1;
	logic                take_s1;
	logic                first_s1;
	logic [RTT_W-1:0]    scaled_s1;

	// Stage 2 state and carried fields
	logic                valid_s2;
	logic [RTT_W-1:0]    dev_q;
	logic [RTT_W-1:0]    est_s2;
	logic [WINDOW_W-1:0] window_s2;
	logic                rtt_valid_s2;
	logic                dup_s2;

	logic [WINDOW_W-1:0] window_d;
	logic [WINDOW_W-1:0] ssthresh_d;
	logic [WINDOW_W-1:0] ack_count_d;
	logic [WINDOW_W-1:0] ack_count_inc;
	logic [RTT_W-1:0]    scaled;
	logic [SUM_W-1:0]    est_sum;
	logic [RTT_W-1:0]    diff;
	logic [RTT_W+1:0]    dev_sum;
	logic [SUM_W-1:0]    rto_sum;
	logic [SUM_W-RTT_FRAC-1:0] rto_wide;
	logic [TIME_W-1:0]   rto_sat;
	logic [TIME_W-1:0]   rto_d;

	// Advance the whole pipe unless the output holds an untaken result
	assign en        = !out_valid || out_ready;
	assign pop_ready = en;
	assign pop       = pop_valid && en;

	// Stage 1: window update
	assign ack_count_inc = ack_count_q + 16'd1;

	always_comb begin
		window_d    = window_q;
		ssthresh_d  = ssthresh_q;
		ack_count_d = ack_count_q;
		case (pop_item.act)
			ACT_SHRINK: begin
				ssthresh_d  = (window_q > 16'd1) ? (window_q >> 1) : 16'd1;
				window_d    = 16'd1;
				ack_count_d = '0;
			end
			ACT_GROW: begin
				if (window_q < ssthresh_q) begin
					if (window_q < MAX_WINDOW) begin
						window_d = window_q + 16'd1;
					end
				end else if (ack_count_inc >= window_q) begin
					if (window_q < MAX_WINDOW) begin
						window_d = window_q + 16'd1;
					end
					ack_count_d = '0;
				end else begin
					ack_count_d = ack_count_inc;
				end
			end
			default: begin
			end
		endcase
	end

	// Stage 1: smoothed RTT, est' = (7*est + S) >> 3
	assign scaled  = {pop_item.sample, {RTT_FRAC{1'b0}}};
	assign est_sum = {est_q, 3'b000} - {3'b000, est_q} + {3'b000, scaled};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			window_q     <= 16'd1;
			ssthresh_q   <= RST_INITIAL_SSTHRESH;
			ack_count_q  <= '0;
			est_q        <= '0;
			rtt_valid_q  <= 1'b0;
			default_to_q <= RST_DEFAULT_TIMEOUT;
		end else begin
			if (en) begin
				valid_s1 <= pop_valid;
			end
			if (pop) begin
				window_q    <= window_d;
				ssthresh_q  <= ssthresh_d;
				ack_count_q <= ack_count_d;
				if (pop_item.take) begin
					est_q       <= rtt_valid_q ? est_sum[SUM_W-1:3] : scaled;
					rtt_valid_q <= 1'b1;
				end
			end
			if (cfg_valid && cfg_index == CFG_INITIAL_SSTHRESH) begin
				ssthresh_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == CFG_DEFAULT_TIMEOUT) begin
				default_to_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dup_s1    <= pop_item.dup;
			take_s1   <= pop_item.take;
			first_s1  <= pop_item.take && !rtt_valid_q;
			scaled_s1 <= scaled;
		end
	end

	// Stage 2: deviation, dev' = (3*dev + |S - est'|) >> 2
	assign diff    = (scaled_s1 >= est_q) ? (scaled_s1 - est_q) : (est_q - scaled_s1);
	assign dev_sum = {1'b0, dev_q, 1'b0} + {2'b00, dev_q} + {2'b00, diff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			dev_q    <= '0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			if (valid_s1 && take_s1) begin
				dev_q <= first_s1 ? (scaled_s1 >> 1) : dev_sum[RTT_W+1:2];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			est_s2       <= est_q;
			window_s2    <= window_q;
			rtt_valid_s2 <= rtt_valid_q;
			dup_s2       <= dup_s1;
		end
	end

	// Stage 3: RTO = ceil(est + 4*dev), at least 1, saturated; default timeout (at least 1) before any sample
	assign rto_sum  = {3'b000, est_s2} + {1'b0, dev_q, 2'b00} + RND;
	assign rto_wide = rto_sum[SUM_W-1:RTT_FRAC];
	assign rto_sat  = (|rto_wide[SUM_W-RTT_FRAC-1:TIME_W]) ? '1 : rto_wide[TIME_W-1:0];

	always_comb begin
		if (rtt_valid_s2) begin
			rto_d = (rto_sat == '0) ? TIME_W'(1) : rto_sat;
		end else if (default_to_q == '0) begin
			rto_d = TIME_W'(1);
		end else begin
			rto_d = TIME_W'(default_to_q);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			window_datagrams      <= window_s2;
			retransmit_timeout_ms <= rto_d;
			duplicate_seen        <= dup_s2;
		end
	end

endmodule

`default_nettype wire

// ----- src/congestion_window_rtt_estimator_core.sv -----
// Channel | Handshake           | Payload
// in      | in_valid/in_ready   | operation, timed_out, acked_sequence,
//         |                     | acked_send_time_ms, ack_arrival_time_ms
// out     | out_valid/out_ready | window_datagrams, retransmit_timeout_ms, duplicate_seen
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ready is high; each passes through the
// front register, two-entry queue and three back stages including the output register.
// The rate is set by the window and smoothed-RTT update loop in back stage 1.
// Reset is asynchronous and active low; no clearing pass follows it.
// While the output is stalled the front keeps accepting until the queue is full.
// cfg_ready is always high; writes take effect on the next cycle.
`default_nettype none

module congestion_window_rtt_estimator_core
	import cwre_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 operation,
	input  wire logic                 timed_out,
	input  wire logic [SEQ_W-1:0]     acked_sequence,
	input  wire logic [TIME_W-1:0]    acked_send_time_ms,
	input  wire logic [TIME_W-1:0]    ack_arrival_time_ms,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [WINDOW_W-1:0]       window_datagrams,
	output logic [TIME_W-1:0]         retransmit_timeout_ms,
	output logic                      duplicate_seen,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	assign cfg_ready = 1'b1;

	// Accept and classify
	cwre_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.operation           (operation),
		.timed_out           (timed_out),
		.acked_sequence      (acked_sequence),
		.acked_send_time_ms  (acked_send_time_ms),
		.ack_arrival_time_ms (ack_arrival_time_ms),
		.push_valid          (push_valid),
		.push_ready          (push_ready),
		.push_item           (push_item)
	);

	// Decouple front and back
	cwre_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// Update window and RTT state, produce results
	cwre_back u_back (
		.clk                   (clk),
		.arst_n                (arst_n),
		.pop_valid             (pop_valid),
		.pop_ready             (pop_ready),
		.pop_item              (pop_item),
		.cfg_valid             (cfg_valid),
		.cfg_index             (cfg_index),
		.cfg_data              (cfg_data),
		.out_valid             (out_valid),
		.out_ready             (out_ready),
		.window_datagrams      (window_datagrams),
		.retransmit_timeout_ms (retransmit_timeout_ms),
		.duplicate_seen        (duplicate_seen)
	);

endmodule

`default_nettype wire

// ----- src/cwre_checker.sv -----
`default_nettype none

`include "congestion_window_rtt_estimator_core_assert.svh"

module cwre_checker
	import cwre_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [WINDOW_W-1:0] window_datagrams,
	input wire logic [TIME_W-1:0]   retransmit_timeout_ms,
	input wire logic                duplicate_seen
);

	// Window is never empty
	`CWRE_ASSERT_NOW(a_window_nonzero, out_valid, window_datagrams != '0, "window is zero")

	// Timeout is at least one millisecond
	`CWRE_ASSERT_NOW(a_rto_nonzero, out_valid, retransmit_timeout_ms != '0, "timeout is zero")

	// A duplicate ack collapses the window
	`CWRE_ASSERT_NOW(a_dup_collapse, out_valid && duplicate_seen, window_datagrams == 16'd1, "duplicate without collapse")

	// A stalled result holds
	`CWRE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(window_datagrams) && $stable(retransmit_timeout_ms) && $stable(duplicate_seen), "stalled result changed")

endmodule

bind congestion_window_rtt_estimator_core cwre_checker u_cwre_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.out_valid             (out_valid),
	.out_ready             (out_ready),
	.window_datagrams      (window_datagrams),
	.retransmit_timeout_ms (retransmit_timeout_ms),
	.duplicate_seen        (duplicate_seen)
);

`default_nettype wire

// ----- tb/sv/congestion_window_rtt_estimator_core_tb.sv -----
module congestion_window_rtt_estimator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cwre_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam int unsigned DRAIN_CYCLES  = 10;
	localparam int unsigned MISMATCH_SHOW = 10;
	localparam int unsigned PHASE_EVENTS  = 305;
	localparam int unsigned GROWTH_ACKS   = 96;
	localparam logic [CFG_W-1:0] GROWTH_SSTHRESH = 16'd32;

	// One result transaction of the controller
	typedef struct packed {
		logic [WINDOW_W-1:0] window;
		logic [TIME_W-1:0]   timeout;
		logic                dup;
	} cc_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 operation = OP_SEND;
	logic                 timed_out = 1'b0;
	logic [SEQ_W-1:0]     acked_sequence = '0;
	logic [TIME_W-1:0]    acked_send_time_ms = '0;
	logic [TIME_W-1:0]    ack_arrival_time_ms = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [WINDOW_W-1:0]  window_datagrams;
	logic [TIME_W-1:0]    retransmit_timeout_ms;
	logic                 duplicate_seen;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_INITIAL_SSTHRESH;
	logic [CFG_W-1:0]     cfg_data = '0;

	// Controller state mirrored by the predictor
	logic [WINDOW_W-1:0] mir_window = 16'd1;
	logic [WINDOW_W-1:0] mir_ssthresh = RST_INITIAL_SSTHRESH;
	logic [WINDOW_W-1:0] mir_avoid_count = '0;
	logic [63:0]         mir_srtt = '0;
	logic [63:0]         mir_rttvar = '0;
	bit                  mir_rtt_seen = 1'b0;
	bit                  mir_ack_seen = 1'b0;
	logic [SEQ_W-1:0]    mir_last_seq = '0;
	logic [CFG_W-1:0]    mir_cfg_timeout = RST_DEFAULT_TIMEOUT;

	cc_result_t  expected_results[$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned ready_hold = 0;
	bit          in_idle_en = 1'b0;
	bit          out_idle_en = 1'b0;

	congestion_window_rtt_estimator_core u_top (
		.clk                   (clk),
		.arst_n                (arst_n),
		.in_valid              (in_valid),
		.in_ready              (in_ready),
		.operation             (operation),
		.timed_out             (timed_out),
		.acked_sequence        (acked_sequence),
		.acked_send_time_ms    (acked_send_time_ms),
		.ack_arrival_time_ms   (ack_arrival_time_ms),
		.out_valid             (out_valid),
		.out_ready             (out_ready),
		.window_datagrams      (window_datagrams),
		.retransmit_timeout_ms (retransmit_timeout_ms),
		.duplicate_seen        (duplicate_seen),
		.cfg_valid             (cfg_valid),
		.cfg_ready             (cfg_ready),
		.cfg_index             (cfg_index),
		.cfg_data              (cfg_data)
	);

	always #6 clk = ~clk;

	// Idle length: mostly short, now and then long
	function automatic int unsigned idle_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 75) return $urandom_range(1, 3);
		if (roll < 95) return $urandom_range(4, 8);
		return $urandom_range(12, 30);
	endfunction

	// Halve the threshold and drop the window to one datagram
	function automatic void shrink_mirror();
		mir_ssthresh = (mir_window > 16'd1) ? (mir_window >> 1) : 16'd1;
		mir_window = 16'd1;
		mir_avoid_count = '0;
	endfunction

	// Advance the mirrored controller by one event and return its result
	function automatic cc_result_t predict_event(input logic op, input logic tmo,
			input logic [SEQ_W-1:0] seq, input logic [TIME_W-1:0] sent,
			input logic [TIME_W-1:0] arrived);
		cc_result_t        res;
		logic [TIME_W-1:0] rtt_ms;
		logic [63:0]       fixed_sample;
		logic [63:0]       diff;
		logic [63:0]       sum;
		logic [63:0]       rto;
		res.dup = 1'b0;
		if (op == OP_SEND) begin
			if (tmo)
				shrink_mirror();
		end else begin
			if (mir_ack_seen && seq == mir_last_seq) begin
				res.dup = 1'b1;
				shrink_mirror();
			end else begin
				// Take an RTT sample unless the ack predates the send
				if (arrived >= sent) begin
					rtt_ms = arrived - sent;
					fixed_sample = {32'd0, rtt_ms} << RTT_FRAC;
					if (!mir_rtt_seen) begin
						mir_srtt = fixed_sample;
						mir_rttvar = fixed_sample >> 1;
						mir_rtt_seen = 1'b1;
					end else begin
						mir_srtt = (7 * mir_srtt + fixed_sample) >> 3;
						diff = (fixed_sample >= mir_srtt) ? fixed_sample - mir_srtt
							: mir_srtt - fixed_sample;
						mir_rttvar = (3 * mir_rttvar + diff) >> 2;
					end
				end
				// Grow: one per ack in slow start, one per window in avoidance
				if (mir_window < mir_ssthresh) begin
					if (mir_window < MAX_WINDOW)
						mir_window++;
				end else begin
					mir_avoid_count++;
					if (mir_avoid_count >= mir_window) begin
						if (mir_window < MAX_WINDOW)
							mir_window++;
						mir_avoid_count = '0;
					end
				end
			end
			mir_last_seq = seq;
			mir_ack_seen = 1'b1;
		end
		res.window = mir_window;
		if (!mir_rtt_seen) begin
			res.timeout = (mir_cfg_timeout == '0) ? 32'd1 : {16'd0, mir_cfg_timeout};
		end else begin
			sum = mir_srtt + (mir_rttvar << 2);
			rto = (sum + (64'd1 << RTT_FRAC) - 64'd1) >> RTT_FRAC;
			if (rto == 64'd0)
				rto = 64'd1;
			if (rto > 64'hFFFF_FFFF)
				rto = 64'hFFFF_FFFF;
			res.timeout = rto[TIME_W-1:0];
		end
		return res;
	endfunction

	// Send one event transaction and record its expected result
	task automatic push_event(input logic op, input logic tmo, input logic [SEQ_W-1:0] seq,
			input logic [TIME_W-1:0] sent, input logic [TIME_W-1:0] arrived);
		int unsigned gap;
		gap = (in_idle_en && $urandom_range(0, 2) == 0) ? idle_len() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		timed_out <= tmo;
		acked_sequence <= seq;
		acked_send_time_ms <= sent;
		ack_arrival_time_ms <= arrived;
		do @(posedge clk); while (in_ready !== 1'b1);
		expected_results.push_back(predict_event(op, tmo, seq, sent, arrived));
	endtask

	// Stop sending and let every outstanding result come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write both registers while the controller is idle
	task automatic program_registers(input logic [CFG_W-1:0] ssthresh,
			input logic [CFG_W-1:0] timeout);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_INITIAL_SSTHRESH;
		cfg_data <= ssthresh;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		mir_ssthresh = ssthresh;
		cfg_index <= CFG_DEFAULT_TIMEOUT;
		cfg_data <= timeout;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		mir_cfg_timeout = timeout;
		cfg_valid <= 1'b0;
	endtask

	// Zero and full registers, seen before any RTT sample exists
	task automatic test_register_extremes();
		program_registers(16'd0, 16'd0);
		push_event(OP_SEND, 1'b0, 32'd0, 32'd0, 32'd0);
		// first ack with sequence zero is new; it predates its send
		push_event(OP_ACK, 1'b0, 32'd0, 32'd100, 32'd50);
		push_event(OP_ACK, 1'b0, 32'd1, 32'd200, 32'd100);
		program_registers(16'hFFFF, 16'hFFFF);
		push_event(OP_SEND, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_event(OP_ACK, 1'b0, 32'd2, 32'd300, 32'd0);
		program_registers(RST_INITIAL_SSTHRESH, RST_DEFAULT_TIMEOUT);
	endtask

	// Every event kind, duplicates and the timeout flag on acks
	task automatic test_event_kinds();
		push_event(OP_SEND, 1'b1, 32'd0, 32'd0, 32'd0);
		// flag ignored on an ack; a zero sample floors the timeout at one
		push_event(OP_ACK, 1'b1, 32'd10, 32'd5000, 32'd5000);
		push_event(OP_ACK, 1'b0, 32'd10, 32'd5000, 32'd5100);
		push_event(OP_ACK, 1'b0, 32'd11, 32'd5000, 32'd5120);
		push_event(OP_ACK, 1'b0, 32'd12, 32'd5200, 32'd5100);
		push_event(OP_SEND, 1'b0, 32'd12, 32'd0, 32'd0);
		push_event(OP_ACK, 1'b0, 32'd12, 32'd5300, 32'd5400);
		push_event(OP_SEND, 1'b1, 32'd0, 32'd0, 32'd0);
	endtask

	// Field extremes, including the largest sample saturating the timeout
	task automatic test_field_extremes();
		push_event(OP_ACK, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
		push_event(OP_ACK, 1'b0, 32'd0, 32'hFFFF_FFFF, 32'd0);
		push_event(OP_ACK, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_event(OP_ACK, 1'b1, 32'h5555_5555, 32'd0, 32'd0);
		push_event(OP_ACK, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
		push_event(OP_SEND, 1'b1, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);
	endtask

	// Climb through slow start, then run avoidance rounds back to back
	task automatic test_window_growth();
		logic [SEQ_W-1:0]  seq;
		logic [TIME_W-1:0] stamp;
		in_idle_en = 1'b0;
		out_idle_en = 1'b0;
		push_event(OP_SEND, 1'b1, 32'd0, 32'd0, 32'd0);
		program_registers(GROWTH_SSTHRESH, RST_DEFAULT_TIMEOUT);
		seq = 32'h1000_0000;
		repeat (GROWTH_ACKS) begin
			seq++;
			stamp = $urandom;
			push_event(OP_ACK, 1'b0, seq, stamp, stamp + $urandom_range(0, 500));
		end
		// drop from the top with a repeated ack
		push_event(OP_ACK, 1'b0, seq, 32'd0, 32'd10);
	endtask

	// Mostly well-formed ack streams with random content and some noise
	task automatic test_random_traffic();
		int unsigned       pick;
		int unsigned       dup_pct;
		logic              op;
		logic              tmo;
		logic [SEQ_W-1:0]  seq;
		logic [TIME_W-1:0] sent;
		logic [TIME_W-1:0] arrived;
		logic [TIME_W-1:0] clock_ms;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					program_registers(16'd1, 16'd1);
				end
				1: begin
					program_registers(16'hFFFF, 16'hFFFF);
				end
				2: begin
					program_registers(16'd0, 16'd0);
				end
				default: begin
					program_registers(CFG_W'($urandom_range(0, 64)),
						CFG_W'($urandom_range(1, 65535)));
				end
			endcase
			in_idle_en = (phase != 3);
			out_idle_en = (phase != 4);
			dup_pct = $urandom_range(2, 20);
			clock_ms = $urandom;
			repeat (PHASE_EVENTS) begin
				clock_ms += $urandom_range(0, 40);
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					op = OP_SEND;
					tmo = ($urandom_range(0, 3) == 0);
					seq = $urandom;
					sent = $urandom;
					arrived = $urandom;
				end else begin
					op = OP_ACK;
					tmo = ($urandom_range(0, 7) == 0);
					pick = $urandom_range(0, 99);
					if (pick < dup_pct)
						seq = mir_last_seq;
					else if (pick < 92)
						seq = mir_last_seq + $urandom_range(1, 4);
					else
						seq = $urandom;
					pick = $urandom_range(0, 99);
					if (pick < 75) begin
						sent = clock_ms - $urandom_range(0, 3000);
						arrived = clock_ms;
					end else if (pick < 88) begin
						sent = clock_ms;
						arrived = clock_ms - $urandom_range(1, 2000);
					end else begin
						sent = $urandom;
						arrived = $urandom;
					end
				end
				push_event(op, tmo, seq, sent, arrived);
			end
		end
	endtask

	// Count a mismatch; show only the first few
	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= MISMATCH_SHOW)
			$display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what,
				want, got);
	endtask

	// Hold out_ready low for random stretches
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold--;
		end else if (out_idle_en && $urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			ready_hold = idle_len();
		end else begin
			out_ready <= 1'b1;
			ready_hold = $urandom_range(0, 6);
		end
	end

	// Check each result transaction against the oldest expectation
	always @(posedge clk) begin
		cc_result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_results.size() == 0) begin
				note_mismatch("result with none expected", 32'd0, {16'd0, window_datagrams});
			end else begin
				want = expected_results.pop_front();
				if (window_datagrams !== want.window)
					note_mismatch("window_datagrams", {16'd0, want.window},
						{16'd0, window_datagrams});
				if (retransmit_timeout_ms !== want.timeout)
					note_mismatch("retransmit_timeout_ms", want.timeout, retransmit_timeout_ms);
				if (duplicate_seen !== want.dup)
					note_mismatch("duplicate_seen", {31'd0, want.dup}, {31'd0, duplicate_seen});
			end
		end
	end

	// End the run if it hangs
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("congestion_window_rtt_estimator_core regression: fail");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		in_idle_en = 1'b1;
		out_idle_en = 1'b1;
		test_register_extremes();
		test_event_kinds();
		test_field_extremes();
		test_window_growth();
		test_random_traffic();
		wait_idle();
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("congestion_window_rtt_estimator_core regression: pass");
		else
			$display("congestion_window_rtt_estimator_core regression: fail");
		$finish;
	end

endmodule
